// ===== rtl/lut1d_linear_interp_hue_keep_defines.svh =====
// assertion macros shared by the lut block
`ifndef LUT1D_LINEAR_INTERP_HUE_KEEP_DEFINES_SVH
`define LUT1D_LINEAR_INTERP_HUE_KEEP_DEFINES_SVH

// implication checked on every edge outside reset
`define LHK_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lhk check failed");

// next-cycle implication checked outside reset
`define LHK_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lhk check failed");

`endif

// ===== rtl/lhk_pkg.sv =====
`timescale 1ns / 1ps
package lhk_pkg;
	localparam int unsigned DepthDefault = 4096;
	localparam int unsigned AddrWidth    = 12;
	localparam int unsigned DataWidth    = 32;
	localparam int unsigned CfgIdxWidth  = 2;

	typedef enum logic [CfgIdxWidth-1:0] {
		REG_INDEX_STEP  = 2'd0,
		REG_LAST_INDEX  = 2'd1,
		REG_ALPHA_SCALE = 2'd2,
		REG_HUE_KEEP    = 2'd3
	} cfg_reg_t;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_LOAD  = 1'b1;

	// saturate a signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		logic signed [49:0] hi;
		logic signed [49:0] lo;
		hi = 50'sd2147483647;
		lo = -50'sd2147483648;
		if (v > hi) begin
			return 32'sh7fffffff;
		end else if (v < lo) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction
endpackage

// ===== rtl/lut1d_linear_interp_hue_keep.sv =====
`timescale 1ns / 1ps
// a pixel beat passes the input register, divider, hue multiply and output register
// throughput: one beat per cycle while the output is not stalled; every stage takes a new beat each cycle
// a stalled output freezes the whole pipeline; load beats write tables and give no result
// reset: arst_n clears valid bits and returns configuration registers to their defaults
// tables are undefined until written
module lut1d_linear_interp_hue_keep
	import lhk_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = DepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [CfgIdxWidth-1:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic signed [31:0] red_in,
	input  logic signed [31:0] green_in,
	input  logic signed [31:0] blue_in,
	input  logic signed [31:0] alpha_in,
	input  logic        end_of_run,
	input  logic [11:0] entry_index,
	input  logic signed [31:0] entry_red,
	input  logic signed [31:0] entry_green,
	input  logic signed [31:0] entry_blue,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] red_out,
	output logic signed [31:0] green_out,
	output logic signed [31:0] blue_out,
	output logic signed [31:0] alpha_out,
	output logic        end_of_run_out
);
	`include "lut1d_linear_interp_hue_keep_defines.svh"

	localparam int unsigned Aw  = $clog2(TABLE_DEPTH);
	// input stage 1, divider 17, hue multiply 1, output register 1
	// the 5 channel stages run alongside the divider
	localparam int unsigned DivQ = 17;
	localparam int unsigned Lat  = DivQ + 3;

	logic [31:0] index_step_q, alpha_scale_q;
	logic [11:0] last_index_q;
	logic        hue_keep_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_step_q  <= 32'd268369920;
			last_index_q  <= 12'd4095;
			alpha_scale_q <= 32'd65536;
			hue_keep_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_INDEX_STEP:  index_step_q  <= cfg_data;
				REG_LAST_INDEX:  last_index_q  <= cfg_data[11:0];
				REG_ALPHA_SCALE: alpha_scale_q <= cfg_data;
				REG_HUE_KEEP:    hue_keep_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective highest index, capped at the last table entry
	logic [Aw-1:0] lim;
	always_comb begin
		if ({20'd0, last_index_q} > 32'(TABLE_DEPTH - 1)) begin
			lim = Aw'(TABLE_DEPTH - 1);
		end else begin
			lim = Aw'(last_index_q);
		end
	end

	// whole pipeline advances together; an output register holds the result
	logic en;
	logic fire;
	logic [Lat-1:0] vld_q;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	assign fire     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Lat-2:0], fire && (operation == OP_PIXEL)};
		end
	end
	assign out_valid = vld_q[Lat-1];

	logic signed [31:0] cres [3];
	logic signed [31:0] cin  [3];
	logic signed [31:0] wdat [3];
	assign cin[0] = red_in;     assign cin[1] = green_in;     assign cin[2] = blue_in;
	assign wdat[0] = entry_red; assign wdat[1] = entry_green; assign wdat[2] = entry_blue;

	// table writes travel with the beat and land at the read stage,
	// so a load never overtakes a pixel accepted before it
	logic wr_req;
	logic wr_en_s1, wr_en_s2;
	logic [Aw-1:0] wr_addr_s1, wr_addr_s2;
	logic signed [31:0] wdat_s1 [3];
	logic signed [31:0] wdat_s2 [3];
	logic wr_en;
	assign wr_req = fire && (operation == OP_LOAD) &&
		({20'd0, entry_index} < 32'(TABLE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_s1 <= 1'b0;
			wr_en_s2 <= 1'b0;
		end else if (en) begin
			wr_en_s1 <= wr_req;
			wr_en_s2 <= wr_en_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wr_addr_s1 <= Aw'(entry_index);
			wr_addr_s2 <= wr_addr_s1;
			wdat_s1    <= wdat;
			wdat_s2    <= wdat_s1;
		end
	end
	assign wr_en = en && wr_en_s2;

	for (genvar c = 0; c < 3; c++) begin : g_ch
		lhk_chan #(.Depth(TABLE_DEPTH), .Aw(Aw)) u_chan (
			.clk(clk), .en(en), .wr_en(wr_en), .wr_addr(wr_addr_s2),
			.wr_data(wdat_s2[c]), .c_in(cin[c]), .step(index_step_q), .lim(lim),
			.res(cres[c])
		);
	end

	// ordering of the inputs, stage one
	logic [1:0] mn_c, md_c, mx_c;
	always_comb begin
		if (red_in > green_in) begin
			if (green_in > blue_in) begin
				mx_c = 2'd0; md_c = 2'd1; mn_c = 2'd2;
			end else if (red_in > blue_in) begin
				mx_c = 2'd0; md_c = 2'd2; mn_c = 2'd1;
			end else begin
				mx_c = 2'd2; md_c = 2'd0; mn_c = 2'd1;
			end
		end else begin
			if (red_in > blue_in) begin
				mx_c = 2'd1; md_c = 2'd0; mn_c = 2'd2;
			end else if (green_in > blue_in) begin
				mx_c = 2'd1; md_c = 2'd2; mn_c = 2'd0;
			end else begin
				mx_c = 2'd2; md_c = 2'd1; mn_c = 2'd0;
			end
		end
	end

	logic [1:0] mn_s1, md_s1, mx_s1;
	logic [32:0] num_s1, den_s1;
	logic signed [63:0] amul_s1;
	logic eor_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			mn_s1   <= mn_c;
			md_s1   <= md_c;
			mx_s1   <= mx_c;
			num_s1  <= 33'(33'(cin[md_c]) - 33'(cin[mn_c]));
			den_s1  <= 33'(33'(cin[mx_c]) - 33'(cin[mn_c]));
			amul_s1 <= alpha_in * $signed({1'b0, alpha_scale_q});
			eor_s1  <= end_of_run;
		end
	end

	// mid - min fits 33 bits unsigned; hue fraction via pipelined divider
	logic [DivQ-1:0] hq;
	lhk_div #(.QBits(DivQ)) u_div (
		.clk(clk), .en(en), .num(num_s1), .den(den_s1), .quo(hq)
	);

	// delay lines for side data to match the channel and divider depth
	localparam int unsigned Dl = DivQ;
	logic [1:0] mn_d [Dl+1], md_d [Dl+1], mx_d [Dl+1];
	logic       z_d  [Dl+1], eor_d [Dl+1], hk_d [Dl+1];
	logic signed [31:0] a_d [Dl+1];
	logic signed [49:0] arnd;
	assign arnd = 50'((amul_s1 + 64'sd32768) >>> 16);
	assign mn_d[0] = mn_s1; assign md_d[0] = md_s1; assign mx_d[0] = mx_s1;
	assign z_d[0]  = (den_s1 == 33'd0);
	assign eor_d[0] = eor_s1;
	assign hk_d[0] = hue_keep_q;
	assign a_d[0]  = ((amul_s1 + 64'sd32768) >>> 16) > 64'sd2147483647 ? 32'sh7fffffff :
		(((amul_s1 + 64'sd32768) >>> 16) < -64'sd2147483648 ? 32'sh80000000 : arnd[31:0]);
	for (genvar k = 0; k < Dl; k++) begin : g_dl
		always_ff @(posedge clk) begin
			if (en) begin
				mn_d[k+1] <= mn_d[k]; md_d[k+1] <= md_d[k]; mx_d[k+1] <= mx_d[k];
				z_d[k+1] <= z_d[k]; eor_d[k+1] <= eor_d[k];
				hk_d[k+1] <= hk_d[k]; a_d[k+1] <= a_d[k];
			end
		end
	end

	// channel results are ready ahead of the quotient; hold them until the quotient lands
	localparam int unsigned Cd = DivQ + 1 - 5;
	logic signed [31:0] r_d [3][Cd+1];
	for (genvar c = 0; c < 3; c++) begin : g_cd
		assign r_d[c][0] = cres[c];
		for (genvar k = 0; k < Cd; k++) begin : g_k
			always_ff @(posedge clk) begin
				if (en) begin
					r_d[c][k+1] <= r_d[c][k];
				end
			end
		end
	end

	// multiply stage: hue fraction times new chroma
	logic signed [31:0] rs [3];
	assign rs[0] = r_d[0][Cd]; assign rs[1] = r_d[1][Cd]; assign rs[2] = r_d[2][Cd];
	logic signed [51:0] hm_s;
	logic signed [31:0] res_s [3];
	logic signed [31:0] nmin_s, a_s;
	logic [1:0] md_s; logic z_s, hk_s, eor_s;
	always_ff @(posedge clk) begin
		if (en) begin
			hm_s   <= $signed({1'b0, hq}) * (33'(rs[mx_d[Dl]]) - 33'(rs[mn_d[Dl]]));
			res_s  <= rs;
			nmin_s <= rs[mn_d[Dl]];
			md_s   <= md_d[Dl];
			z_s    <= z_d[Dl];
			hk_s   <= hk_d[Dl];
			a_s    <= a_d[Dl];
			eor_s  <= eor_d[Dl];
		end
	end

	logic signed [51:0] hr;
	logic signed [31:0] midv;
	assign hr = (hm_s + 52'sd32768) >>> 16;
	assign midv = z_s ? nmin_s : sat32(50'(hr) + 50'(nmin_s));

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			red_out   <= (hk_s && md_s == 2'd0) ? midv : res_s[0];
			green_out <= (hk_s && md_s == 2'd1) ? midv : res_s[1];
			blue_out  <= (hk_s && md_s == 2'd2) ? midv : res_s[2];
			alpha_out <= a_s;
			end_of_run_out <= eor_s;
		end
	end

	`LHK_ASSERT_IMP(a_ready_hold, out_valid && !out_ready, !in_ready)
	`LHK_ASSERT_NEXT(a_load_no_result, fire && operation == OP_LOAD && en, !vld_q[0])
	`LHK_ASSERT_NEXT(a_pix_enters, fire && operation == OP_PIXEL, vld_q[0])
endmodule

// ===== rtl/lhk_div.sv =====
`timescale 1ns / 1ps
// pipelined restoring divider: quotient of num*2^(QBits-1) / den (2^16 at the default), one bit per stage
// the quotient fits QBits because num never exceeds den
module lhk_div #(
	parameter int unsigned QBits = 17
) (
	input  logic        clk,
	input  logic        en,
	input  logic [32:0] num,
	input  logic [32:0] den,
	output logic [QBits-1:0] quo
);
	logic [32:0] rem_s [QBits+1];
	logic [32:0] den_s [QBits+1];
	logic [QBits-1:0] q_s [QBits+1];
	logic [49:0] numx_s [QBits+1];

	// upper dividend bits start as the remainder, the rest shift in from the top
	assign rem_s[0] = {1'b0, num[32:1]};
	assign den_s[0] = den;
	assign q_s[0]   = '0;
	assign numx_s[0] = {num[0], 49'd0};

	for (genvar k = 0; k < QBits; k++) begin : g_st
		logic [33:0] trial;
		logic [32:0] nrem;
		logic        bitv;
		always_comb begin
			trial = {rem_s[k], numx_s[k][49]};
			bitv  = (trial >= {1'b0, den_s[k]});
			nrem  = bitv ? 33'(trial - {1'b0, den_s[k]}) : trial[32:0];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= nrem;
				den_s[k+1]  <= den_s[k];
				q_s[k+1]    <= {q_s[k][QBits-2:0], bitv};
				numx_s[k+1] <= {numx_s[k][48:0], 1'b0};
			end
		end
	end
	assign quo = q_s[QBits];
endmodule

// ===== rtl/lhk_chan.sv =====
`timescale 1ns / 1ps
// one color channel: position, table read, interpolation
module lhk_chan
	import lhk_pkg::*;
#(
	parameter int unsigned Depth = DepthDefault,
	parameter int unsigned Aw    = $clog2(Depth)
) (
	input  logic                clk,
	input  logic                en,
	input  logic                wr_en,
	input  logic [Aw-1:0]       wr_addr,
	input  logic signed [31:0]  wr_data,
	input  logic signed [31:0]  c_in,
	input  logic [31:0]         step,
	input  logic [Aw-1:0]       lim,
	output logic signed [31:0]  res
);
	logic signed [31:0] mem_q [Depth];
	logic [63:0]  prod_s1;
	logic [Aw+16-1:0] p_s2;
	logic [Aw-1:0] lo_s2, hi_s2;
	logic [Aw+16-1:0] lim_s1;
	logic [16:0]  d_s3;
	logic signed [31:0] lv_s3, hv_s3;
	logic signed [32:0] diff_s4;
	logic [16:0]  d_s4;
	logic signed [31:0] hv_s4, hv_s5;
	logic signed [50:0] mul_s5;
	logic [Aw-1:0] low_c, high_c;
	logic [Aw+16-1:0] p_c;
	logic [47:0] pq;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_comb begin
		pq  = prod_s1[63:16];
		if (pq > 48'(lim_s1) ) begin
			p_c = lim_s1;
		end else begin
			p_c = pq[Aw+16-1:0];
		end
		low_c  = p_c[Aw+16-1:16];
		high_c = ({1'b0, low_c} + 1'b1 < {1'b0, lim_s1[Aw+16-1:16]}) ?
			Aw'(low_c + 1'b1) : lim_s1[Aw+16-1:16];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= (c_in > 0) ? 64'(32'(c_in)) * 64'(step) : 64'd0;
			lim_s1  <= {lim, 16'd0};
			p_s2    <= p_c;
			lo_s2   <= low_c;
			hi_s2   <= high_c;
			d_s3    <= 17'({hi_s2, 16'd0} - p_s2);
			lv_s3   <= mem_q[lo_s2];
			hv_s3   <= mem_q[hi_s2];
			diff_s4 <= 33'(lv_s3) - 33'(hv_s3);
			d_s4    <= d_s3;
			hv_s4   <= hv_s3;
			mul_s5  <= $signed({1'b0, d_s4}) * diff_s4;
			hv_s5   <= hv_s4;
		end
	end

	logic signed [50:0] rnd;
	assign rnd = (mul_s5 + 51'sd32768) >>> 16;
	assign res = sat32(50'(rnd) + 50'(hv_s5));
endmodule
